// ===== sv/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, codes and constants for the track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int unsigned MAX_VLQ_BYTES_DEF = 4;
   localparam int unsigned TEMPO_BITS_DEF    = 24;

   localparam int unsigned CSR_W   = 24;
   localparam int unsigned VALUE_W = 45;
   localparam int unsigned BYTE_W  = 8;

   localparam logic [CSR_W-1:0]   INIT_TEMPO = 24'd500000;
   localparam logic [VALUE_W-1:0] VALUE_MAX  = '1;

   // delay = delta * tempo / 250
   localparam logic [7:0]   DELAY_DIV   = 8'd250;
   localparam logic [127:0] DELAY_DIV_W = 128'd250;
   localparam int unsigned  DIV_SHIFT   = 8;

   // result kinds
   localparam logic [1:0] KIND_DELAY = 2'd0;
   localparam logic [1:0] KIND_MSG   = 2'd1;
   localparam logic [1:0] KIND_TEMPO = 2'd2;

   // status codes
   localparam logic [3:0] ST_NOTE_OFF  = 4'h8;
   localparam logic [3:0] ST_NOTE_ON   = 4'h9;
   localparam logic [3:0] ST_CTRL      = 4'hb;
   localparam logic [3:0] ST_PROG      = 4'hc;
   localparam logic [3:0] ST_BEND      = 4'he;
   localparam logic [7:0] ST_META      = 8'hff;
   localparam logic [7:0] ST_SYSEX     = 8'hf0;
   localparam logic [7:0] META_TEMPO   = 8'h51;

   typedef enum logic [2:0] {
      PH_DELTA,
      PH_STATUS,
      PH_DATA,
      PH_META_TYPE,
      PH_META_LEN,
      PH_SYSEX_LEN,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       msg_last;
   } tag_type;

   // ceil(2^(bits+8) / 250): exact reciprocal for any bits-wide dividend
   function automatic logic [127:0] div_recip(input int unsigned bits);
      logic [127:0] num;
      num = 128'd1 << (bits + DIV_SHIFT);
      return (num + DELAY_DIV_W - 128'd1) / DELAY_DIV_W;
   endfunction

endpackage

// ===== sv/midi_track_event_parser.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser
// Parses a standard MIDI file track one byte per transfer: delay per event,
// forwarded channel messages, and tempo updates from tempo meta events.
//
//   channel   dir  tdata / data            tuser   tlast
//   req_      in   [7:0] data_byte         -       last_in
//   rsp_      out  [44:0] value            kind    msg_last
//   csr_      in   [23:0] initial_tempo    -       -
//
// One byte per cycle while the delay pipeline keeps req_tready high; each result passes
// through the delay pipeline (reciprocal multiplies, partial products, saturating sum).
// Synchronous reset clears parser state and loads tempo 500000.
// With rsp_tready low the six pipeline stages fill before req_tready drops.
// ----------------------------------------------------------------------------
module midi_track_event_parser #(
   parameter int unsigned MAX_VLQ_BYTES = mtep_pkg::MAX_VLQ_BYTES_DEF,
   parameter int unsigned TEMPO_BITS    = mtep_pkg::TEMPO_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tlast,   // last_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,   // [44:0] value, rest zero
   output logic [1:0]                    rsp_tuser,   // [1:0] kind
   output logic                          rsp_tlast,   // msg_last
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mtep_pkg::CSR_W-1:0]    csr_data     // [23:0] initial_tempo
);
   import mtep_pkg::*;

   localparam int unsigned DW = 7 * MAX_VLQ_BYTES;
   localparam int unsigned TW = TEMPO_BITS;
   localparam int unsigned NW = $clog2(MAX_VLQ_BYTES + 1);
   localparam logic [DW-1:0] VLQ_MAX = '1;

   phase_type phase_ff, phase_in;
   logic [CSR_W-1:0] init_tempo_ff;
   logic [DW-1:0] delta_ff, delta_in;
   logic [DW-1:0] skip_ff, skip_in;
   logic [NW-1:0] vlq_cnt_ff, vlq_cnt_in;
   logic [1:0]    left_ff, left_in;
   logic [TW-1:0] tempo_now_ff, tempo_now_in;
   logic [TW-1:0] tacc_ff, tacc_in;
   logic          is_tempo_ff, is_tempo_in;

   logic          req_fire;
   logic [7:0]    b;
   logic [3:0]    hi;
   logic          is_chan;
   logic [DW-1:0] vlq_src, vlq_acc;
   logic [NW-1:0] vlq_cnt_new;
   logic          vlq_sat, vlq_done;
   logic [1:0]    left_dec;
   logic [DW-1:0] skip_dec;
   logic [TW-1:0] tacc_shift;

   logic          emit;
   tag_type       emit_tag;
   logic [TW-1:0] emit_tempo;
   logic          pipe_ready;
   tag_type       out_tag;
   logic [VALUE_W-1:0] out_value;

   assign req_fire = req_tvalid && req_tready;
   assign b        = req_tdata;
   assign hi       = req_tdata[7:4];
   assign is_chan  = (hi == ST_NOTE_OFF) || (hi == ST_NOTE_ON) || (hi == ST_CTRL)
                  || (hi == ST_BEND) || (hi == ST_PROG);

   assign vlq_src     = (phase_ff == PH_DELTA) ? delta_ff : skip_ff;
   assign vlq_sat     = vlq_cnt_ff >= NW'(MAX_VLQ_BYTES);
   assign vlq_acc     = vlq_sat ? VLQ_MAX : DW'({vlq_src, b[6:0]});
   assign vlq_done    = !b[7];
   assign vlq_cnt_new = vlq_done ? '0 : (vlq_sat ? vlq_cnt_ff : vlq_cnt_ff + NW'(1));
   assign left_dec    = left_ff - 2'd1;
   assign skip_dec    = skip_ff - DW'(1);
   assign tacc_shift  = is_tempo_ff ? TW'({tacc_ff, b}) : tacc_ff;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_DELTA: begin
            if (vlq_done) phase_in = PH_STATUS;
         end
         PH_STATUS: begin
            priority if (is_chan)      phase_in = PH_DATA;
            else if (b == ST_META)     phase_in = PH_META_TYPE;
            else if (b == ST_SYSEX)    phase_in = PH_SYSEX_LEN;
            else                       phase_in = PH_DELTA;
         end
         PH_DATA: begin
            if (left_dec == 2'd0) phase_in = PH_DELTA;
         end
         PH_META_TYPE: phase_in = PH_META_LEN;
         PH_META_LEN, PH_SYSEX_LEN: begin
            if (vlq_done) phase_in = (vlq_acc != '0) ? PH_SKIP : PH_DELTA;
         end
         PH_SKIP: begin
            if (skip_dec == '0) phase_in = PH_DELTA;
         end
         default: phase_in = PH_DELTA;
      endcase
      if (req_tlast) phase_in = PH_DELTA;
   end

   // datapath and results
   always_comb begin
      delta_in     = delta_ff;
      skip_in      = skip_ff;
      vlq_cnt_in   = vlq_cnt_ff;
      left_in      = left_ff;
      tempo_now_in = tempo_now_ff;
      tacc_in      = tacc_ff;
      is_tempo_in  = is_tempo_ff;
      emit         = 1'b0;
      emit_tag     = '{kind: KIND_DELAY, msg_last: 1'b0};
      emit_tempo   = tempo_now_ff;
      unique case (phase_ff)
         PH_DELTA: begin
            vlq_cnt_in = vlq_cnt_new;
            if (vlq_done) begin
               emit     = 1'b1;
               delta_in = '0;
            end else begin
               delta_in = vlq_acc;
            end
         end
         PH_STATUS: begin
            if (is_chan) begin
               emit          = 1'b1;
               emit_tag.kind = KIND_MSG;
               emit_tempo    = TW'(b);
               left_in       = (hi == ST_PROG) ? 2'd1 : 2'd2;
            end else if (b == ST_SYSEX) begin
               vlq_cnt_in  = '0;
               skip_in     = '0;
               is_tempo_in = 1'b0;
            end
         end
         PH_DATA: begin
            left_in           = left_dec;
            emit              = 1'b1;
            emit_tag.kind     = KIND_MSG;
            emit_tag.msg_last = (left_dec == 2'd0);
            emit_tempo        = TW'(b);
         end
         PH_META_TYPE: begin
            is_tempo_in = (b == META_TEMPO);
            vlq_cnt_in  = '0;
            skip_in     = '0;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            vlq_cnt_in = vlq_cnt_new;
            skip_in    = vlq_acc;
            if (vlq_done) begin
               tacc_in = '0;
               if (vlq_acc == '0 && phase_ff == PH_META_LEN && is_tempo_ff) begin
                  tempo_now_in  = '0;
                  emit          = 1'b1;
                  emit_tag.kind = KIND_TEMPO;
                  emit_tempo    = '0;
               end
            end
         end
         PH_SKIP: begin
            tacc_in = tacc_shift;
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               if (is_tempo_ff) begin
                  tempo_now_in  = tacc_shift;
                  emit          = 1'b1;
                  emit_tag.kind = KIND_TEMPO;
                  emit_tempo    = tacc_shift;
               end
               is_tempo_in = 1'b0;
            end
         end
         default: begin
            delta_in     = '0;
            skip_in      = '0;
            vlq_cnt_in   = '0;
            left_in      = 2'd0;
            tacc_in      = '0;
            is_tempo_in  = 1'b0;
            tempo_now_in = TW'(init_tempo_ff);
         end
      endcase
      if (req_tlast) begin
         delta_in     = '0;
         skip_in      = '0;
         vlq_cnt_in   = '0;
         left_in      = 2'd0;
         tacc_in      = '0;
         is_tempo_in  = 1'b0;
         tempo_now_in = TW'(init_tempo_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DELTA;
         init_tempo_ff <= INIT_TEMPO;
         delta_ff      <= '0;
         skip_ff       <= '0;
         vlq_cnt_ff    <= '0;
         left_ff       <= 2'd0;
         tempo_now_ff  <= TW'(INIT_TEMPO);
         tacc_ff       <= '0;
         is_tempo_ff   <= 1'b0;
      end else begin
         if (csr_valid) init_tempo_ff <= csr_data;
         if (req_fire) begin
            phase_ff     <= phase_in;
            delta_ff     <= delta_in;
            skip_ff      <= skip_in;
            vlq_cnt_ff   <= vlq_cnt_in;
            left_ff      <= left_in;
            tempo_now_ff <= tempo_now_in;
            tacc_ff      <= tacc_in;
            is_tempo_ff  <= is_tempo_in;
         end
      end
   end

   assign csr_ready  = 1'b1;
   assign req_tready = pipe_ready;

   mtep_delay_pipe #(
      .DELTA_BITS (DW),
      .TEMPO_BITS (TW)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && emit),
      .in_ready  (pipe_ready),
      .in_tag    (emit_tag),
      .in_delta  (vlq_acc),
      .in_tempo  (emit_tempo),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tag   (out_tag),
      .out_value (out_value)
   );

   assign rsp_tdata = {3'b000, out_value};
   assign rsp_tuser = out_tag.kind;
   assign rsp_tlast = out_tag.msg_last;

endmodule

// ===== sv/mtep_delay_pipe.sv =====
// ----------------------------------------------------------------------------
// Delay pipeline
// Six-stage result pipeline computing delta*tempo/250 with saturation;
// message bytes and tempo updates ride through in order. Per-stage ready
// lets bubbles collapse.
// ----------------------------------------------------------------------------
module mtep_delay_pipe #(
   parameter int unsigned DELTA_BITS = 28,
   parameter int unsigned TEMPO_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  mtep_pkg::tag_type                  in_tag,
   input  logic [DELTA_BITS-1:0]              in_delta,
   input  logic [TEMPO_BITS-1:0]              in_tempo,
   output logic                               out_valid,
   input  logic                               out_ready,
   output mtep_pkg::tag_type                  out_tag,
   output logic [mtep_pkg::VALUE_W-1:0]       out_value
);
   import mtep_pkg::*;

   localparam int unsigned DW  = DELTA_BITS;
   localparam int unsigned TW  = TEMPO_BITS;
   localparam int unsigned DPW = 2 * DW + 1;
   localparam int unsigned TPW = 2 * TW + 1;
   localparam int unsigned DRW = DW + 8;
   localparam int unsigned TRW = TW + 8;
   localparam int unsigned AW  = DW + TW;
   localparam int unsigned SW  = AW + 1;
   localparam int unsigned FW  = (SW + 1 > VALUE_W + 1) ? SW + 1 : VALUE_W + 1;
   localparam int unsigned CPW = 33;

   localparam logic [DW:0] MD = (DW + 1)'(div_recip(DW));
   localparam logic [TW:0] MT = (TW + 1)'(div_recip(TW));
   localparam logic [16:0] MC = 17'(div_recip(16));

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff;
   logic [DW-1:0] d1_ff, d2_ff, d3_ff;
   logic [TW-1:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff;
   logic [DW-1:0] dq2_ff, dq3_ff;
   logic [TW-1:0] tq2_ff, tq3_ff;
   logic [7:0]    dr3_ff, tr3_ff;
   logic [AW-1:0] a4_ff;
   logic [DRW-1:0] b4_ff;
   logic [15:0]   c4_ff;
   logic [SW-1:0] s5_ff;
   logic [7:0]    cq5_ff;
   logic [VALUE_W-1:0] val6_ff;

   logic [DPW-1:0] dq_prod;
   logic [TPW-1:0] tq_prod;
   logic [DRW-1:0] dq_x250;
   logic [TRW-1:0] tq_x250;
   logic [CPW-1:0] cq_prod;
   logic [FW-1:0]  sum_in;
   logic [VALUE_W-1:0] val6_in;

   assign rdy6     = !v6_ff || out_ready;
   assign rdy5     = !v5_ff || rdy6;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign dq_prod = DPW'(d1_ff) * DPW'(MD);
   assign tq_prod = TPW'(t1_ff) * TPW'(MT);
   assign dq_x250 = DRW'(dq2_ff) * DRW'(DELAY_DIV);
   assign tq_x250 = TRW'(tq2_ff) * TRW'(DELAY_DIV);
   assign cq_prod = CPW'(c4_ff) * CPW'(MC);
   assign sum_in  = FW'(s5_ff) + FW'(cq5_ff);

   always_comb begin
      if (tag5_ff.kind == KIND_DELAY) begin
         val6_in = (sum_in > FW'(VALUE_MAX)) ? VALUE_MAX : VALUE_W'(sum_in);
      end else begin
         val6_in = VALUE_W'(t5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         tag1_ff <= in_tag;
         d1_ff   <= in_delta;
         t1_ff   <= in_tempo;
      end
      if (rdy2) begin
         tag2_ff <= tag1_ff;
         d2_ff   <= d1_ff;
         t2_ff   <= t1_ff;
         dq2_ff  <= DW'(dq_prod >> (DW + DIV_SHIFT));
         tq2_ff  <= TW'(tq_prod >> (TW + DIV_SHIFT));
      end
      if (rdy3) begin
         tag3_ff <= tag2_ff;
         d3_ff   <= d2_ff;
         t3_ff   <= t2_ff;
         dq3_ff  <= dq2_ff;
         tq3_ff  <= tq2_ff;
         dr3_ff  <= 8'(DRW'(d2_ff) - dq_x250);
         tr3_ff  <= 8'(TRW'(t2_ff) - tq_x250);
      end
      if (rdy4) begin
         tag4_ff <= tag3_ff;
         t4_ff   <= t3_ff;
         a4_ff   <= AW'(d3_ff) * AW'(tq3_ff);
         b4_ff   <= DRW'(dq3_ff) * DRW'(tr3_ff);
         c4_ff   <= 16'(dr3_ff) * 16'(tr3_ff);
      end
      if (rdy5) begin
         tag5_ff <= tag4_ff;
         t5_ff   <= t4_ff;
         s5_ff   <= SW'(a4_ff) + SW'(b4_ff);
         cq5_ff  <= 8'(cq_prod >> (16 + DIV_SHIFT));
      end
      if (rdy6) begin
         tag6_ff <= tag5_ff;
         val6_ff <= val6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_tag   = tag6_ff;
   assign out_value = val6_ff;

endmodule

// ===== verif/midi_track_event_parser_test.sv =====
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Feeds track bytes through the req_ stream and checks every rsp_ transfer
// against an in-bench parser model: a directed byte table first, then random
// tracks (channel messages, tempo and other meta events, sysex, dropped
// status bytes, overlong numbers, truncated tracks, noise) under several
// initial tempo settings, with random idle cycles on both streams.
// ----------------------------------------------------------------------------
module midi_track_event_parser_test;
   import mtep_pkg::*;

   localparam int unsigned LIMIT   = 500000;
   localparam int unsigned DRAIN   = 20;
   localparam int unsigned N_ITEMS = 800;
   localparam int unsigned N_SETS  = 6;

   typedef logic [27:0] vlq_type;
   localparam vlq_type VLQ_ALL = '1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [44:0] value;
      logic        mlast;
   } parsed_type;

   typedef struct packed {
      logic [7:0] b;
      logic       eot;
      logic       typed;
      parsed_type res;
   } script_row_type;

   logic          clock;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata  = '0;
   logic          req_tlast  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [47:0]   rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          rsp_tlast;
   logic          csr_valid  = 1'b0;
   logic          csr_ready;
   logic [CSR_W-1:0] csr_data = '0;

   // parser model state
   phase_type     ph;
   vlq_type       delta_acc;
   vlq_type       skip_left;
   logic [2:0]    vlq_n;
   logic [1:0]    data_left;
   logic [23:0]   tempo_cur;
   logic [23:0]   tempo_build;
   logic [23:0]   tempo_init;
   logic          tempo_meta;

   parsed_type     awaited_q[$];
   script_row_type script_q[$];
   logic [8:0]     track_q[$];

   bit            calm = 1'b0;
   int unsigned   cycles = 0;
   int unsigned   mismatches = 0;
   int unsigned   n_bytes = 0;
   int unsigned   n_tracks = 0;
   int unsigned   n_checked = 0;
   int unsigned   n_kind[3] = '{0, 0, 0};

   midi_track_event_parser u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles, awaited_q.size());
         $display("midi_track_event_parser verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 24);
   end

   // ---------------------------------------------------------------- model
   function automatic parsed_type make_out(input logic [1:0] k, input logic [44:0] v,
                                           input logic ml);
      parsed_type o;
      o.kind  = k;
      o.value = v;
      o.mlast = ml;
      return o;
   endfunction

   function automatic bit is_voice(input logic [3:0] hi);
      return hi == ST_NOTE_OFF || hi == ST_NOTE_ON || hi == ST_CTRL ||
             hi == ST_PROG || hi == ST_BEND;
   endfunction

   function automatic void restart_parser();
      ph          = PH_DELTA;
      delta_acc   = '0;
      skip_left   = '0;
      vlq_n       = '0;
      data_left   = '0;
      tempo_build = '0;
      tempo_meta  = 1'b0;
      tempo_cur   = tempo_init;
   endfunction

   // shifts one byte into a variable-length number, 1 when the number ends
   function automatic bit vlq_shift(inout vlq_type acc, input logic [7:0] b);
      if (vlq_n >= MAX_VLQ_BYTES_DEF) begin
         acc = VLQ_ALL;
      end else begin
         acc   = {acc[20:0], b[6:0]};
         vlq_n = vlq_n + 3'd1;
      end
      if (b[7]) return 1'b0;
      vlq_n = '0;
      return 1'b1;
   endfunction

   function automatic logic [44:0] delay_us(input vlq_type d, input logic [23:0] t);
      logic [63:0] q;
      q = (64'(d) * 64'(t)) / 64'(DELAY_DIV);
      if (q > 64'(VALUE_MAX)) return VALUE_MAX;
      return q[44:0];
   endfunction

   function automatic bit parse_byte(input logic [7:0] b, input logic eot,
                                     output parsed_type r);
      bit has;
      has = 1'b0;
      r   = '0;
      case (ph)
         PH_DELTA: begin
            if (vlq_shift(delta_acc, b)) begin
               r         = make_out(KIND_DELAY, delay_us(delta_acc, tempo_cur), 1'b0);
               has       = 1'b1;
               delta_acc = '0;
               ph        = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (is_voice(b[7:4])) begin
               r         = make_out(KIND_MSG, 45'(b), 1'b0);
               has       = 1'b1;
               data_left = (b[7:4] == ST_PROG) ? 2'd1 : 2'd2;
               ph        = PH_DATA;
            end else if (b == ST_META) begin
               ph = PH_META_TYPE;
            end else if (b == ST_SYSEX) begin
               vlq_n      = '0;
               skip_left  = '0;
               tempo_meta = 1'b0;
               ph         = PH_SYSEX_LEN;
            end else begin
               ph = PH_DELTA;
            end
         end
         PH_DATA: begin
            data_left = data_left - 2'd1;
            r         = make_out(KIND_MSG, 45'(b), data_left == 2'd0);
            has       = 1'b1;
            if (data_left == 2'd0) ph = PH_DELTA;
         end
         PH_META_TYPE: begin
            tempo_meta = (b == META_TEMPO);
            vlq_n      = '0;
            skip_left  = '0;
            ph         = PH_META_LEN;
         end
         PH_META_LEN, PH_SYSEX_LEN: begin
            if (vlq_shift(skip_left, b)) begin
               tempo_build = '0;
               if (skip_left != '0) begin
                  ph = PH_SKIP;
               end else begin
                  if (ph == PH_META_LEN && tempo_meta) begin
                     tempo_cur = '0;
                     r         = make_out(KIND_TEMPO, '0, 1'b0);
                     has       = 1'b1;
                  end
                  ph = PH_DELTA;
               end
            end
         end
         PH_SKIP: begin
            if (tempo_meta) tempo_build = {tempo_build[15:0], b};
            skip_left = skip_left - vlq_type'(1);
            if (skip_left == '0) begin
               if (tempo_meta) begin
                  tempo_cur = tempo_build;
                  r         = make_out(KIND_TEMPO, 45'(tempo_build), 1'b0);
                  has       = 1'b1;
               end
               tempo_meta = 1'b0;
               ph         = PH_DELTA;
            end
         end
         default: restart_parser();
      endcase
      if (eot) restart_parser();
      return has;
   endfunction

   // ---------------------------------------------------------------- check
   task automatic report_mismatch(input string msg);
      if (mismatches < 40) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : rsp_check
      parsed_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = awaited_q.pop_front();
            n_checked++;
            if (want.kind <= KIND_TEMPO) n_kind[want.kind]++;
            if (rsp_tuser !== want.kind)
               report_mismatch($sformatf("kind %0d, expected %0d", rsp_tuser, want.kind));
            if (rsp_tdata !== {3'b000, want.value})
               report_mismatch($sformatf("value %0d, expected %0d", rsp_tdata, want.value));
            if (rsp_tlast !== want.mlast)
               report_mismatch($sformatf("msg_last %0b, expected %0b", rsp_tlast, want.mlast));
         end
      end
   end

   // ---------------------------------------------------------------- drive
   task automatic drive_byte(input logic [7:0] b, input logic eot);
      while (!calm && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_bytes++;
   endtask

   task automatic feed(input logic [7:0] b, input logic eot);
      parsed_type r;
      drive_byte(b, eot);
      if (parse_byte(b, eot, r)) awaited_q.push_back(r);
   endtask

   task automatic write_tempo(input logic [23:0] v);
      while (awaited_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      tempo_init = v;
   endtask

   task automatic row(input logic [7:0] b, input logic eot = 1'b0);
      script_row_type s;
      s.b     = b;
      s.eot   = eot;
      s.typed = 1'b0;
      s.res   = '0;
      script_q.push_back(s);
   endtask

   task automatic row_t(input logic [7:0] b, input logic eot, input logic [1:0] k,
                        input logic [44:0] v, input logic ml);
      script_row_type s;
      s.b     = b;
      s.eot   = eot;
      s.typed = 1'b1;
      s.res   = make_out(k, v, ml);
      script_q.push_back(s);
   endtask

   // ---------------------------------------------------------------- tracks
   task automatic put_vlq(input int unsigned v);
      logic [7:0] grp[$];
      grp.push_front({1'b0, v[6:0]});
      v = v >> 7;
      while (v != 0) begin
         grp.push_front({1'b1, v[6:0]});
         v = v >> 7;
      end
      foreach (grp[i]) track_q.push_back({1'b0, grp[i]});
   endtask

   task automatic put_overlong();
      int unsigned n;
      n = $urandom_range(5, 6);
      repeat (n - 1) track_q.push_back({2'b01, 7'($urandom)});
      track_q.push_back({2'b00, 7'($urandom)});
   endtask

   task automatic put_payload(input int unsigned n);
      repeat (n) track_q.push_back({1'b0, 8'($urandom)});
   endtask

   task automatic make_event(output bit broken);
      int unsigned pick;
      int unsigned len;
      logic [3:0]  hi;
      logic [7:0]  b;
      broken = 1'b0;
      pick   = $urandom_range(99);
      if (pick < 50) put_vlq($urandom_range(0, 127));
      else if (pick < 85) put_vlq($urandom_range(128, 2097151));
      else if (pick < 95) put_vlq($urandom_range(2097152, 268435455));
      else put_overlong();

      pick = $urandom_range(99);
      if (pick < 55) begin
         case ($urandom_range(4))
            0: hi = ST_NOTE_OFF;
            1: hi = ST_NOTE_ON;
            2: hi = ST_CTRL;
            3: hi = ST_PROG;
            default: hi = ST_BEND;
         endcase
         track_q.push_back({1'b0, hi, 4'($urandom)});
         repeat ((hi == ST_PROG) ? 1 : 2) begin
            b = 8'($urandom);
            if ($urandom_range(99) < 85) b[7] = 1'b0;
            track_q.push_back({1'b0, b});
         end
      end else if (pick < 70) begin
         len = ($urandom_range(99) < 70) ? 3 : $urandom_range(0, 5);
         track_q.push_back({1'b0, ST_META});
         track_q.push_back({1'b0, META_TEMPO});
         put_vlq(len);
         put_payload(len);
      end else if (pick < 78) begin
         len = ($urandom_range(99) < 90) ? $urandom_range(0, 6) : $urandom_range(128, 300);
         track_q.push_back({1'b0, ST_META});
         track_q.push_back({1'b0, 8'($urandom)});
         put_vlq(len);
         put_payload(len);
      end else if (pick < 86) begin
         len = $urandom_range(0, 8);
         track_q.push_back({1'b0, ST_SYSEX});
         put_vlq(len);
         put_payload(len);
      end else if (pick < 95) begin
         do b = 8'($urandom); while (is_voice(b[7:4]) || b == ST_META || b == ST_SYSEX);
         track_q.push_back({1'b0, b});
      end else begin
         // overlong length: the skip never ends, so the track is cut here
         if ($urandom_range(1)) begin
            track_q.push_back({1'b0, ST_META});
            track_q.push_back({1'b0, $urandom_range(1) ? META_TEMPO : 8'($urandom)});
         end else begin
            track_q.push_back({1'b0, ST_SYSEX});
         end
         put_overlong();
         put_payload($urandom_range(0, 4));
         broken = 1'b1;
      end
   endtask

   task automatic run_track();
      int unsigned n_ev;
      bit          broken;
      track_q = {};
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 10))
            track_q.push_back({1'($urandom_range(99) < 10), 8'($urandom)});
      end else begin
         n_ev   = $urandom_range(2, 12);
         broken = 1'b0;
         while (n_ev != 0 && !broken) begin
            make_event(broken);
            n_ev--;
         end
         if (!broken && $urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) if (track_q.size() > 1) void'(track_q.pop_back());
      end
      track_q[track_q.size() - 1][8] = 1'b1;
      foreach (track_q[i]) feed(track_q[i][7:0], track_q[i][8]);
      n_tracks++;
   endtask

   // ---------------------------------------------------------------- main
   initial begin : stimulus
      parsed_type  r;
      logic [23:0] t_set;
      int unsigned target;

      tempo_init = INIT_TEMPO;
      restart_parser();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      row_t(8'h00, 1'b0, KIND_DELAY, 45'd0, 1'b0);
      row_t(8'h90, 1'b0, KIND_MSG, 45'h90, 1'b0);
      row(8'h3c);
      row_t(8'hff, 1'b0, KIND_MSG, 45'hff, 1'b1);      // data byte, bit 7 set
      row(8'h81);
      row_t(8'h00, 1'b0, KIND_DELAY, 45'd256000, 1'b0);
      row(8'hc5);
      row_t(8'h80, 1'b0, KIND_MSG, 45'h80, 1'b1);
      row(8'h00); row(8'h85); row(8'h00); row(8'h7f);
      row(8'h00); row(8'hb0); row(8'h07); row(8'h64);
      row(8'h00); row(8'hef); row(8'h00); row(8'h40);
      row(8'h00); row(8'hff); row(8'h51); row(8'h04);   // long tempo payload
      row(8'h12); row(8'hff); row(8'hff);
      row_t(8'hff, 1'b0, KIND_TEMPO, 45'hffffff, 1'b0);
      repeat (5) row(8'h80);                            // overlong delta
      row(8'h00);
      row(8'hf0); row(8'h01); row(8'hf7);
      row_t(8'h00, 1'b0, KIND_DELAY, 45'd0, 1'b0);
      row(8'hff); row(8'h51);
      row_t(8'h00, 1'b0, KIND_TEMPO, 45'd0, 1'b0);      // zero-length tempo
      row_t(8'h7f, 1'b0, KIND_DELAY, 45'd0, 1'b0);
      row(8'ha0);                                       // dropped status
      row_t(8'h05, 1'b1, KIND_DELAY, 45'd0, 1'b0);      // last byte
      row_t(8'h40, 1'b0, KIND_DELAY, 45'd128000, 1'b0); // tempo reloaded

      foreach (script_q[i]) begin
         if (script_q[i].typed) begin
            drive_byte(script_q[i].b, script_q[i].eot);
            void'(parse_byte(script_q[i].b, script_q[i].eot, r));
            awaited_q.push_back(script_q[i].res);
         end else begin
            feed(script_q[i].b, script_q[i].eot);
         end
      end
      req_tvalid <= 1'b0;

      for (int s = 0; s < N_SETS; s++) begin
         case (s)
            0: t_set = 24'd0;
            1: t_set = 24'hffffff;
            2: t_set = 24'd1;
            4: t_set = INIT_TEMPO;
            default: t_set = 24'($urandom);
         endcase
         write_tempo(t_set);
         calm   = (s == 2);
         target = n_bytes + N_ITEMS / N_SETS;
         while (n_bytes < target) run_track();
         req_tvalid <= 1'b0;
      end
      calm = 1'b0;

      while (awaited_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      $display("%0d track bytes in %0d tracks over %0d initial tempo settings",
               n_bytes, n_tracks, N_SETS);
      $display("%0d results checked: %0d delays, %0d message bytes, %0d tempo loads",
               n_checked, n_kind[0], n_kind[1], n_kind[2]);
      if (mismatches == 0 && awaited_q.size() == 0) begin
         $display("midi_track_event_parser verification clean");
      end else begin
         $display("midi_track_event_parser verification failed");
      end
      $finish;
   end

endmodule
